// ===== rtl/core/stable_priority_task_queue_assert.svh =====
// ----------------------------------------------------------------------------
// stable_priority_task_queue_assert
// Assertion macros used by the queue checker.
// ----------------------------------------------------------------------------
// each macro expects clk and arst_n to be visible where it is used
`ifndef STABLE_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_TASK_QUEUE_ASSERT_SVH

// condition in this cycle implies consequence in the next
`define SPTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition implies consequence in the same cycle
`define SPTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sptq_pkg.sv =====
// ----------------------------------------------------------------------------
// sptq_pkg
// Types, codes and sizes shared by the stable priority task queue.
// ----------------------------------------------------------------------------
package sptq_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int FUNC_W      = 3;
	localparam int ID_W        = 8;
	localparam int PRI_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int LENGTH_W    = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_PRIO_INSERT = 3'd0,
		FN_PUSH_FRONT  = 3'd1,
		FN_APPEND_BACK = 3'd2,
		FN_POP_FRONT   = 3'd3,
		FN_REMOVE      = 3'd4,
		FN_CLEAR       = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_DUP      = 3'd4
	} result_code_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT
	} cell_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   task_id;
		logic [PRI_W-1:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     popped_id;
		logic [PRI_W-1:0]    popped_priority;
		logic [LENGTH_W-1:0] length;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

endpackage

// ===== rtl/core/sptq_cell.sv =====
// ----------------------------------------------------------------------------
// sptq_cell
// One queue slot: holds an entry, compares it with the request and loads
// from the request, its left or its right neighbour on command.
// ----------------------------------------------------------------------------
module sptq_cell (
	input  logic                         clk,
	input  sptq_pkg::cell_cmd_t          cmd,
	input  sptq_pkg::entry_t             ins,
	input  sptq_pkg::entry_t             left,
	input  sptq_pkg::entry_t             right,
	input  logic [sptq_pkg::ID_W-1:0]    task_id,
	input  logic [sptq_pkg::PRI_W-1:0]   priority_req,
	output sptq_pkg::entry_t             entry,
	output logic                         match,
	output logic                         le
);
	import sptq_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD:  entry_q <= ins;
			CELL_LEFT:  entry_q <= left;
			CELL_RIGHT: entry_q <= right;
			default:    entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign match = (entry_q.id == task_id);
	assign le    = (entry_q.pri <= priority_req);

endmodule

// ===== rtl/core/sptq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sptq_ctrl
// Decodes a request against the cell flags: finds the insert or remove
// position, issues one command per cell and forms the response.
// ----------------------------------------------------------------------------
module sptq_ctrl #(
	parameter int ENTRIES = sptq_pkg::DEF_ENTRIES,
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input  logic                                 go,
	input  sptq_pkg::req_t                       req,
	input  logic [CW-1:0]                        count_q,
	input  logic [ENTRIES-1:0]                   match,
	input  logic [ENTRIES-1:0]                   le,
	input  sptq_pkg::entry_t                     front,
	output sptq_pkg::cell_cmd_t [ENTRIES-1:0]    cmd,
	output logic [CW-1:0]                        count_d,
	output sptq_pkg::rsp_t                       rsp
);
	import sptq_pkg::*;

	logic [ENTRIES-1:0] occ;
	logic [ENTRIES-1:0] occle;
	logic [ENTRIES-1:0] hit;
	logic [ENTRIES-1:0] lead_le;
	logic [ENTRIES-1:0] thru;
	logic [ENTRIES-1:0] ins_ge;
	logic [ENTRIES-1:0] prev_ge;
	logic [ENTRIES-1:0] shl;
	logic               dup;
	logic               full;
	logic               empty;
	logic               is_ins;
	logic               do_ins;
	logic               do_rem;

	function automatic logic [ENTRIES-1:0] below_mask(input int idx);
		return (ENTRIES'(1) << idx) - ENTRIES'(1);
	endfunction

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			occ[i] = (CW'(i) < count_q);
		end
		occle = occ & le;
		hit   = occ & match;
		// every slot up to and including i is occupied with priority not above the request
		for (int i = 0; i < ENTRIES; i++) begin
			lead_le[i] = &(occle | ~(below_mask(i) | (ENTRIES'(1) << i)));
			thru[i]    = |(hit & (below_mask(i) | (ENTRIES'(1) << i)));
		end
		dup   = |hit;
		full  = (count_q == CW'(ENTRIES));
		empty = (count_q == '0);

		case (req.func)
			FN_PUSH_FRONT:  ins_ge = '1;
			FN_APPEND_BACK: ins_ge = ~occ;
			default:        ins_ge = ~lead_le;
		endcase
		prev_ge = {ins_ge[ENTRIES-2:0], 1'b0};
		shl     = (req.func == FN_POP_FRONT) ? '1 : thru;

		is_ins = req.func inside {FN_PRIO_INSERT, FN_PUSH_FRONT, FN_APPEND_BACK};
		do_ins = 1'b0;
		do_rem = 1'b0;
		rsp    = '0;
		count_d = count_q;

		case (req.func)
			FN_PRIO_INSERT, FN_PUSH_FRONT, FN_APPEND_BACK: begin
				if (dup) begin
					rsp.status = ST_DUP;
				end else if (full) begin
					rsp.status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					rsp.status = ST_EMPTY;
				end else begin
					do_rem              = 1'b1;
					rsp.popped_id       = front.id;
					rsp.popped_priority = front.pri;
					count_d             = count_q - CW'(1);
				end
			end
			FN_REMOVE: begin
				if (empty) begin
					rsp.status = ST_EMPTY;
				end else if (!dup) begin
					rsp.status = ST_NOTFOUND;
				end else begin
					do_rem  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			FN_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		rsp.length = LENGTH_W'(count_d);

		for (int i = 0; i < ENTRIES; i++) begin
			cmd[i] = CELL_HOLD;
			if (go && do_ins && is_ins && ins_ge[i]) begin
				cmd[i] = prev_ge[i] ? CELL_LEFT : CELL_LOAD;
			end else if (go && do_rem && shl[i]) begin
				cmd[i] = CELL_RIGHT;
			end
		end
	end

endmodule

// ===== rtl/core/stable_priority_task_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// Ordered queue of task ids with priorities, kept in a row of shifting cells.
//
//   channel  dir  payload  handshake
//   req      in   req_t    req_valid / req_stall
//   rsp      out  rsp_t    rsp_valid / rsp_stall
//
// One request beat per cycle unless stalled; its response appears next cycle.
// Every cell compares with the request at once and the whole row shifts in
// the same cycle, so the cycle is set by the compare and position search.
// Reset clears the length and the response valid; slot contents stay as-is.
// A stalled response holds and stalls the request side until it is taken.
// ----------------------------------------------------------------------------
module stable_priority_task_queue #(
	parameter int ENTRIES = sptq_pkg::DEF_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sptq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sptq_pkg::rsp_t   rsp
);
	import sptq_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	logic                        accept;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_d;
	logic                        rsp_valid_q;
	rsp_t                        rsp_q;
	rsp_t                        rsp_d;
	entry_t                      ins;
	entry_t [ENTRIES-1:0]        ents;
	entry_t [ENTRIES-1:0]        left_of;
	entry_t [ENTRIES-1:0]        right_of;
	cell_cmd_t [ENTRIES-1:0]     cmd;
	logic [ENTRIES-1:0]          match;
	logic [ENTRIES-1:0]          le;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign ins      = '{id: req.task_id, pri: req.priority_req};
	assign left_of  = {ents[ENTRIES-2:0], ins};
	assign right_of = {ents[ENTRIES-1], ents[ENTRIES-1:1]};

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		sptq_cell u_cell (
			.clk          (clk),
			.cmd          (cmd[g]),
			.ins          (ins),
			.left         (left_of[g]),
			.right        (right_of[g]),
			.task_id      (req.task_id),
			.priority_req (req.priority_req),
			.entry        (ents[g]),
			.match        (match[g]),
			.le           (le[g])
		);
	end

	sptq_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.go      (accept),
		.req     (req),
		.count_q (count_q),
		.match   (match),
		.le      (le),
		.front   (ents[0]),
		.cmd     (cmd),
		.count_d (count_d),
		.rsp     (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/sptq_checker.sv =====
// ----------------------------------------------------------------------------
// sptq_checker
// Port-level checks on the task queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_priority_task_queue_assert.svh"

module sptq_checker #(
	parameter int ENTRIES = sptq_pkg::DEF_ENTRIES
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input sptq_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sptq_pkg::rsp_t rsp
);
	import sptq_pkg::*;

	// an accepted request always yields a response beat next cycle
	`SPTQ_ASSERT_NEXT(a_rsp_follows, req_valid && !req_stall, rsp_valid, "response missing")

	`SPTQ_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response moved")

	// only a successful pop carries an id and a priority
	`SPTQ_ASSERT_NOW(a_pop_zero, rsp_valid && (rsp.status != ST_OK), (rsp.popped_id == '0) && (rsp.popped_priority == '0), "popped fields set on failure")

	`SPTQ_ASSERT_NEXT(a_clear_len, req_valid && !req_stall && (req.func == FN_CLEAR), rsp.length == '0, "clear left entries")

	`SPTQ_ASSERT_NOW(a_len_range, rsp_valid && (ENTRIES < 32), rsp.length <= LENGTH_W'(ENTRIES), "length beyond capacity")

endmodule

bind stable_priority_task_queue sptq_checker #(.ENTRIES(ENTRIES)) u_sptq_checker (.*);
